// ===== hw/rtl/s5ahp_pkg.sv =====
// shared types and constants for the socks5 address header parser
`timescale 1ns / 1ps

package s5ahp_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 4;
    localparam int unsigned ErrW    = 2;
    localparam int unsigned PosW    = 9;

    localparam logic [ByteW-1:0] ATYP_IPV4 = 8'h01;
    localparam logic [ByteW-1:0] ATYP_NAME = 8'h03;
    localparam logic [ByteW-1:0] ATYP_IPV6 = 8'h04;

    localparam logic [ByteW-1:0] IPV4_LEN = 8'd4;
    localparam logic [ByteW-1:0] IPV6_LEN = 8'd16;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_CMD   = 4'd1,
        PH_RSV   = 4'd2,
        PH_URSV2 = 4'd3,
        PH_FRAG  = 4'd4,
        PH_ATYP  = 4'd5,
        PH_ADDR  = 4'd6,
        PH_NLEN  = 4'd7,
        PH_NAME  = 4'd8,
        PH_PORT  = 4'd9,
        PH_DONE  = 4'd10,
        PH_ERROR = 4'd11
    } phase_t;

    typedef enum logic [KindW-1:0] {
        FK_VERSION = 4'd0,
        FK_COMMAND = 4'd1,
        FK_RSV     = 4'd2,
        FK_FRAG    = 4'd3,
        FK_ATYP    = 4'd4,
        FK_ADDR    = 4'd5,
        FK_NAMELEN = 4'd6,
        FK_PORT    = 4'd7,
        FK_PAST    = 4'd8,
        FK_ERROR   = 4'd9
    } field_kind_t;

    typedef enum logic [ErrW-1:0] {
        ERR_NONE = 2'd0,
        ERR_RSV  = 2'd1,
        ERR_ATYP = 2'd2
    } err_code_t;

    typedef struct packed {
        field_kind_t      field_kind;
        logic [ByteW-1:0] field_offset;
        logic [ByteW-1:0] byte_value;
        logic             header_done;
        err_code_t        error_code;
        logic [PosW-1:0]  header_length;
    } result_t;

endpackage

// ===== hw/rtl/s5ahp_parser.sv =====
// header phase tracker: tags each accepted byte and advances the parse state
`timescale 1ns / 1ps

module s5ahp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    input  logic                frame_kind,
    output s5ahp_pkg::result_t  result
);
    import s5ahp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [ByteW-1:0]  offset_reg, offset_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic              ipv6_reg, ipv6_next;
    logic [ByteW-1:0]  nlen_reg, nlen_next;
    err_code_t         failed_reg, failed_next;

    phase_t            phase_cur;
    logic [ByteW-1:0]  offset_cur;
    logic [PosW-1:0]   pos_cur;
    logic              ipv6_cur;
    logic [ByteW-1:0]  nlen_cur;
    err_code_t         failed_cur;
    logic [ByteW:0]    offset_inc;
    logic [ByteW-1:0]  addr_need;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            offset_reg <= '0;
            pos_reg    <= '0;
            ipv6_reg   <= 1'b0;
            nlen_reg   <= '0;
            failed_reg <= ERR_NONE;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            pos_reg    <= pos_next;
            ipv6_reg   <= ipv6_next;
            nlen_reg   <= nlen_next;
            failed_reg <= failed_next;
        end
    end

    always_comb begin
        // a frame start clears all state before the byte is parsed
        phase_cur  = frame_start ? PH_START : phase_reg;
        offset_cur = frame_start ? '0 : offset_reg;
        pos_cur    = frame_start ? '0 : pos_reg;
        ipv6_cur   = frame_start ? 1'b0 : ipv6_reg;
        nlen_cur   = frame_start ? '0 : nlen_reg;
        failed_cur = frame_start ? ERR_NONE : failed_reg;

        offset_inc = {1'b0, offset_cur} + {{ByteW{1'b0}}, 1'b1};
        addr_need  = ipv6_cur ? IPV6_LEN : IPV4_LEN;

        phase_next  = phase_cur;
        offset_next = offset_cur;
        ipv6_next   = ipv6_cur;
        nlen_next   = nlen_cur;
        failed_next = failed_cur;

        result.field_kind    = FK_PAST;
        result.field_offset  = '0;
        result.byte_value    = data_byte;
        result.header_done   = 1'b0;
        result.error_code    = ERR_NONE;
        result.header_length = '0;

        unique case (phase_cur)
            PH_START: begin
                if (!frame_kind) begin
                    result.field_kind = FK_VERSION;
                    phase_next = PH_CMD;
                end else begin
                    result.field_kind = FK_RSV;
                    if (data_byte != '0) begin
                        failed_next = ERR_RSV;
                        result.error_code = ERR_RSV;
                        phase_next = PH_ERROR;
                    end else begin
                        phase_next = PH_URSV2;
                    end
                end
            end
            PH_CMD: begin
                result.field_kind = FK_COMMAND;
                phase_next = PH_RSV;
            end
            PH_RSV: begin
                result.field_kind = FK_RSV;
                if (data_byte != '0) begin
                    failed_next = ERR_RSV;
                    result.error_code = ERR_RSV;
                    phase_next = PH_ERROR;
                end else begin
                    phase_next = PH_ATYP;
                end
            end
            PH_URSV2: begin
                result.field_kind   = FK_RSV;
                result.field_offset = 8'd1;
                if (data_byte != '0) begin
                    failed_next = ERR_RSV;
                    result.error_code = ERR_RSV;
                    phase_next = PH_ERROR;
                end else begin
                    phase_next = PH_FRAG;
                end
            end
            PH_FRAG: begin
                result.field_kind = FK_FRAG;
                phase_next = PH_ATYP;
            end
            PH_ATYP: begin
                result.field_kind = FK_ATYP;
                ipv6_next   = (data_byte == ATYP_IPV6);
                offset_next = '0;
                if (data_byte == ATYP_IPV4 || data_byte == ATYP_IPV6) begin
                    phase_next = PH_ADDR;
                end else if (data_byte == ATYP_NAME) begin
                    phase_next = PH_NLEN;
                end else begin
                    failed_next = ERR_ATYP;
                    result.error_code = ERR_ATYP;
                    phase_next = PH_ERROR;
                end
            end
            PH_ADDR: begin
                result.field_kind   = FK_ADDR;
                result.field_offset = offset_cur;
                if (offset_inc >= {1'b0, addr_need}) begin
                    offset_next = '0;
                    phase_next  = PH_PORT;
                end else begin
                    offset_next = offset_inc[ByteW-1:0];
                end
            end
            PH_NLEN: begin
                result.field_kind = FK_NAMELEN;
                nlen_next   = data_byte;
                offset_next = '0;
                phase_next  = (data_byte == '0) ? PH_PORT : PH_NAME;
            end
            PH_NAME: begin
                result.field_kind   = FK_ADDR;
                result.field_offset = offset_cur;
                if (offset_inc >= {1'b0, nlen_cur}) begin
                    offset_next = '0;
                    phase_next  = PH_PORT;
                end else begin
                    offset_next = offset_inc[ByteW-1:0];
                end
            end
            PH_PORT: begin
                result.field_kind   = FK_PORT;
                result.field_offset = offset_cur;
                if (offset_cur != '0) begin
                    result.header_done   = 1'b1;
                    result.header_length = pos_cur + {{(PosW-1){1'b0}}, 1'b1};
                    offset_next = '0;
                    phase_next  = PH_DONE;
                end else begin
                    offset_next = 8'd1;
                end
            end
            PH_ERROR: begin
                result.field_kind = FK_ERROR;
                result.error_code = failed_cur;
            end
            default: begin
                result.field_kind = FK_PAST;
            end
        endcase

        // position saturates and freezes once the header ends or fails
        if (pos_cur != {PosW{1'b1}} && phase_next != PH_DONE && phase_next != PH_ERROR) begin
            pos_next = pos_cur + {{(PosW-1){1'b0}}, 1'b1};
        end else begin
            pos_next = pos_cur;
        end
    end

endmodule

// ===== hw/rtl/socks5_address_header_parser_top.sv =====
// top level of the socks5 address header parser with stream ports
`timescale 1ns / 1ps

// takes one header byte per transfer and returns one tagged byte per transfer,
// in the cycle after it was taken; a new byte is accepted every cycle while the
// result register is empty or being drained. the parse state is a small phase
// machine updated once per byte, so throughput is one byte per clock unless
// the output stalls. frame_kind selects request/reply or udp layout and is sampled
// on the first byte of each header; write it only while no transfer is in flight.

module socks5_address_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // frame_kind
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tuser,       // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // field_offset, byte_value, error_code, header_length
    output logic [3:0]  m_tuser,       // field_kind
    output logic        m_tlast        // header_done
);
    import s5ahp_pkg::*;

    logic     frame_kind_reg;
    logic     out_valid_reg;
    result_t  out_reg;
    result_t  step_result;
    logic     in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_kind_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            frame_kind_reg <= cfg_data;
        end
    end

    s5ahp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .frame_kind  (frame_kind_reg),
        .result      (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.field_kind;
    assign m_tlast  = out_reg.header_done;
    assign m_tdata  = {5'd0, out_reg.header_length, out_reg.error_code,
                       out_reg.byte_value, out_reg.field_offset};

endmodule
